// ===== sv/owsr_pkg.sv =====
// Shared types, codes and helpers of the 1-Wire slave ROM-command layer.
`default_nettype none
package owsr_pkg;

    localparam int RX_BITS  = 64;
    localparam int TX_BITS  = 64;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    localparam logic [15:0] RESET_THR_DEF = 16'd400;
    localparam logic [7:0]  BIT_STD_DEF   = 8'd20;
    localparam logic [7:0]  BIT_OD_DEF    = 8'd6;
    localparam logic [IDX_W-1:0] SEARCH_LAST = 6'd63;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_PRESENCE = 3'd1,
        MODE_AWAIT    = 3'd2,
        MODE_READROM  = 3'd3,
        MODE_MATCH    = 3'd4,
        MODE_SEARCH   = 3'd5,
        MODE_READY    = 3'd6,
        MODE_ACTIVE   = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        CMD_FALL  = 2'd0,
        CMD_RISE  = 2'd1,
        CMD_QUEUE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_STD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_OD    = 3'd4;

    // ROM function commands
    localparam logic [7:0] ROM_READ       = 8'h33;
    localparam logic [7:0] ROM_OD_MATCH   = 8'h69;
    localparam logic [7:0] ROM_MATCH      = 8'h55;
    localparam logic [7:0] ROM_ALARM_SRCH = 8'hEC;
    localparam logic [7:0] ROM_SEARCH     = 8'hF0;
    localparam logic [7:0] ROM_OD_SKIP    = 8'h3C;
    localparam logic [7:0] ROM_SKIP       = 8'hCC;
    localparam logic [7:0] ROM_RESUME     = 8'hA5;

    typedef struct packed {
        logic [63:0] rom_code;
        logic        alarm_active;
        logic [15:0] reset_thr;
        logic [7:0]  bit_thr_std;
        logic [7:0]  bit_thr_od;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       command;
        logic [15:0]      low_time_us;
        logic [63:0]      tx_data;
        logic [CNT_W-1:0] tx_bit_count;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       presence_pulse;
        logic [7:0] rx_byte;
        logic       rx_byte_valid;
        logic       write_done;
        logic [2:0] bus_state;
    } t_result;

    typedef struct packed {
        logic [63:0]      shift;
        logic [CNT_W-1:0] count;
    } t_txq;

    // Append up to 64 bits to the response queue; count saturates at 64.
    function automatic t_txq txq_append(t_txq q, logic [63:0] data, logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] nn;
        logic [63:0]      mask;
        logic [CNT_W:0]   sum;
        t_txq             r;
        nn   = (n > CNT_W'(TX_BITS)) ? CNT_W'(TX_BITS) : n;
        mask = (nn == CNT_W'(TX_BITS)) ? '1 : ~(64'hFFFF_FFFF_FFFF_FFFF << nn[5:0]);
        r    = q;
        if (q.count < CNT_W'(TX_BITS)) begin
            r.shift = q.shift | ((data & mask) << q.count[5:0]);
        end
        sum     = {1'b0, q.count} + {1'b0, nn};
        r.count = (sum > (CNT_W+1)'(TX_BITS)) ? CNT_W'(TX_BITS) : sum[CNT_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/one_wire_slave_rom_layer_top.sv =====
// Top level of the 1-Wire slave ROM-command layer: stream ports, config and pipeline.
// Every request is one bus event: a falling edge (pops one queued response bit and
// reports whether to hold the line low), a rising edge with the measured low time
// (bus reset and presence, or one decoded bit for the ROM commands read, match,
// skip, search, conditional search, resume and the overdrive forms), or a load of
// up to 64 response bits into the send queue, or a no-op. Each request yields exactly one result.
// The block takes one request per clock whenever the downstream side keeps tready
// high: a request sits in the input register, the event logic evaluates it against
// the state registers, and the result lands in the output register. A stalled
// output holds the result and the input register while the state stays untouched.
// Configuration registers (index: 0 ROM code, 1 alarm flag, 2 reset threshold,
// 3 standard bit threshold, 4 overdrive bit threshold) are written through the
// plain write port and must only change while no request is in flight.
`default_nettype none
module one_wire_slave_rom_layer_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request stream
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [15:0] low_time_us, [79:16] tx_data, [86:80] tx_bit_count, [87] zero
    input  wire logic [owsr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]                         i_s_axis_tuser,
    // result stream
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [0] drive_low, [1] presence_pulse, [9:2] rx_byte, [10] rx_byte_valid,
    // [11] write_done, [14:12] bus_state, [15] zero
    output logic [owsr_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [owsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [63:0]                        i_cfg_data
);
    import owsr_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_adv;

    // Advance the pipeline when the output register is free or being drained.
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.bus_state, r_out.write_done, r_out.rx_byte_valid,
                              r_out.rx_byte, r_out.presence_pulse, r_out.drive_low};

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_code     <= '0;
            r_cfg.alarm_active <= 1'b0;
            r_cfg.reset_thr    <= RESET_THR_DEF;
            r_cfg.bit_thr_std  <= BIT_STD_DEF;
            r_cfg.bit_thr_od   <= BIT_OD_DEF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROM_CODE:  r_cfg.rom_code     <= i_cfg_data;
                CFG_ALARM:     r_cfg.alarm_active <= i_cfg_data[0];
                CFG_RESET_THR: r_cfg.reset_thr    <= i_cfg_data[15:0];
                CFG_BIT_STD:   r_cfg.bit_thr_std  <= i_cfg_data[7:0];
                CFG_BIT_OD:    r_cfg.bit_thr_od   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register: capture a request whenever ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.command      <= i_s_axis_tuser;
            r_in.low_time_us  <= i_s_axis_tdata[15:0];
            r_in.tx_data      <= i_s_axis_tdata[79:16];
            r_in.tx_bit_count <= i_s_axis_tdata[86:80];
        end
    end

    // Event logic commits state only when its result moves into the output register.
    owsr_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid && w_adv),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Output register: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_out <= w_result;
        end
    end

endmodule
`default_nettype wire

// ===== sv/owsr_engine.sv =====
// Bus event decoder and ROM-command state machine, one event per cycle while i_valid is high.
`default_nettype none
module owsr_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire owsr_pkg::t_item   i_item,
    input  wire owsr_pkg::t_cfg    i_cfg,
    output owsr_pkg::t_result      o_result
);
    import owsr_pkg::*;

    t_mode            r_mode, n_mode;
    logic             r_od, n_od;
    logic             r_sel, n_sel;
    logic             r_ign, n_ign;
    logic [63:0]      r_tx_shift, n_tx_shift;
    logic [CNT_W-1:0] r_tx_count, n_tx_count;
    logic [IDX_W-1:0] r_sidx, n_sidx;
    logic [63:0]      r_rx_shift, n_rx_shift;
    logic [CNT_W-1:0] r_rx_count, n_rx_count;

    logic       w_fall, w_rise, w_queue, w_tx_has, w_reset, w_bit_ev, w_bit;
    logic       w_rx_room, w_act;
    logic [7:0] w_thr;
    logic [63:0] w_rx_ins;

    assign w_fall    = i_valid && (i_item.command == CMD_FALL);
    assign w_rise    = i_valid && (i_item.command == CMD_RISE);
    assign w_queue   = i_valid && (i_item.command == CMD_QUEUE);
    assign w_tx_has  = (r_tx_count != '0);
    assign w_reset   = w_rise && (i_item.low_time_us >= i_cfg.reset_thr);
    assign w_bit_ev  = w_rise && !w_reset && !r_ign;
    assign w_thr     = r_od ? i_cfg.bit_thr_od : i_cfg.bit_thr_std;
    assign w_bit     = (i_item.low_time_us < {8'd0, w_thr});
    assign w_rx_room = (r_rx_count < CNT_W'(RX_BITS));
    assign w_act     = (r_mode == MODE_ACTIVE) || (r_mode == MODE_READY);
    assign w_rx_ins  = r_rx_shift | (64'(w_bit) << r_rx_count[5:0]);

    // Next state
    always_comb begin
        t_txq       v_q;
        logic [7:0] v_byte;
        logic       v_ab;
        logic       v_idle;
        n_mode     = r_mode;
        n_od       = r_od;
        n_sel      = r_sel;
        n_ign      = r_ign;
        n_tx_shift = r_tx_shift;
        n_tx_count = r_tx_count;
        n_sidx     = r_sidx;
        n_rx_shift = r_rx_shift;
        n_rx_count = r_rx_count;
        v_q        = '{shift: r_tx_shift, count: r_tx_count};
        v_byte     = w_rx_ins[7:0];
        v_ab       = i_cfg.rom_code[r_sidx];
        v_idle     = 1'b0;

        if (w_fall) begin
            if (w_tx_has) begin
                n_tx_count = r_tx_count - CNT_W'(1);
                n_tx_shift = r_tx_shift >> 1;
                n_ign      = 1'b1;
            end else begin
                n_ign = 1'b0;
            end
        end else if (w_reset) begin
            n_mode     = MODE_PRESENCE;
            n_tx_shift = '0;
            n_tx_count = '0;
            n_rx_shift = '0;
            n_rx_count = '0;
            n_ign      = 1'b0;
            n_od       = 1'b0;
            n_sidx     = '0;
        end else if (w_bit_ev) begin
            if (r_mode == MODE_SEARCH) begin
                if (w_bit == v_ab) begin
                    if (r_sidx < SEARCH_LAST) begin
                        n_sidx = r_sidx + IDX_W'(1);
                        v_ab   = i_cfg.rom_code[n_sidx];
                        v_q    = txq_append(v_q, {62'd0, !v_ab, v_ab}, CNT_W'(2));
                        n_tx_shift = v_q.shift;
                        n_tx_count = v_q.count;
                    end else begin
                        n_mode = MODE_ACTIVE;
                        n_sel  = 1'b1;
                    end
                end else begin
                    v_idle = 1'b1;
                end
            end else if (r_mode == MODE_PRESENCE) begin
                n_mode = MODE_AWAIT;
            end else if (r_mode != MODE_IDLE) begin
                if (!w_rx_room) begin
                    v_idle = 1'b1;
                end else begin
                    n_rx_shift = w_rx_ins;
                    n_rx_count = r_rx_count + CNT_W'(1);
                    if ((r_mode == MODE_AWAIT) && (r_rx_count == CNT_W'(7))) begin
                        n_rx_shift = '0;
                        n_rx_count = '0;
                        unique case (v_byte)
                            ROM_READ: begin
                                v_q = txq_append(v_q, i_cfg.rom_code, CNT_W'(64));
                                n_tx_shift = v_q.shift;
                                n_tx_count = v_q.count;
                                n_mode     = MODE_READROM;
                            end
                            ROM_OD_MATCH: begin
                                n_od   = 1'b1;
                                n_mode = MODE_MATCH;
                            end
                            ROM_MATCH: n_mode = MODE_MATCH;
                            ROM_ALARM_SRCH, ROM_SEARCH: begin
                                if ((v_byte == ROM_ALARM_SRCH) && !i_cfg.alarm_active) begin
                                    v_idle = 1'b1;
                                end else begin
                                    n_sidx = '0;
                                    n_mode = MODE_SEARCH;
                                    v_ab   = i_cfg.rom_code[0];
                                    v_q    = txq_append(v_q, {62'd0, !v_ab, v_ab}, CNT_W'(2));
                                    n_tx_shift = v_q.shift;
                                    n_tx_count = v_q.count;
                                end
                            end
                            ROM_OD_SKIP: begin
                                n_od   = 1'b1;
                                n_mode = MODE_READY;
                            end
                            ROM_SKIP: n_mode = MODE_READY;
                            ROM_RESUME: begin
                                if (r_sel) n_mode = MODE_READY;
                                else       v_idle = 1'b1;
                            end
                            default: ;
                        endcase
                    end else if ((r_mode == MODE_MATCH) &&
                                 (r_rx_count == CNT_W'(RX_BITS - 1))) begin
                        n_rx_shift = '0;
                        n_rx_count = '0;
                        if (w_rx_ins == i_cfg.rom_code) begin
                            n_mode = MODE_ACTIVE;
                            n_sel  = 1'b1;
                        end else begin
                            v_idle = 1'b1;
                        end
                    end else if (w_act && (r_rx_count == CNT_W'(7))) begin
                        n_rx_shift = '0;
                        n_rx_count = '0;
                    end
                end
            end
        end else if (w_queue) begin
            v_q = txq_append(v_q, i_item.tx_data, i_item.tx_bit_count);
            n_tx_shift = v_q.shift;
            n_tx_count = v_q.count;
        end

        // drop to idle
        if (v_idle) begin
            n_tx_shift = '0;
            n_tx_count = '0;
            n_rx_shift = '0;
            n_rx_count = '0;
            n_sel      = 1'b0;
            n_ign      = 1'b1;
            n_mode     = MODE_IDLE;
        end
    end

    // Result of the event
    always_comb begin
        logic v_byte_done;
        v_byte_done = w_bit_ev && w_act && (r_rx_count == CNT_W'(7));
        o_result.drive_low      = w_fall && w_tx_has && !r_tx_shift[0];
        o_result.presence_pulse = w_reset;
        o_result.rx_byte_valid  = v_byte_done;
        o_result.rx_byte        = v_byte_done ? w_rx_ins[7:0] : 8'd0;
        o_result.write_done     = w_fall && w_act && (r_tx_count == CNT_W'(1));
        o_result.bus_state      = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_od       <= 1'b0;
            r_sel      <= 1'b0;
            r_ign      <= 1'b0;
            r_tx_shift <= '0;
            r_tx_count <= '0;
            r_sidx     <= '0;
            r_rx_shift <= '0;
            r_rx_count <= '0;
        end else if (i_valid) begin
            r_mode     <= n_mode;
            r_od       <= n_od;
            r_sel      <= n_sel;
            r_ign      <= n_ign;
            r_tx_shift <= n_tx_shift;
            r_tx_count <= n_tx_count;
            r_sidx     <= n_sidx;
            r_rx_shift <= n_rx_shift;
            r_rx_count <= n_rx_count;
        end
    end

endmodule
`default_nettype wire

// ===== verif/tb_one_wire_slave_rom_layer_top.sv =====
// Self-checking testbench for the 1-Wire slave ROM-command layer top level.
`default_nettype none
module tb_one_wire_slave_rom_layer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import owsr_pkg::*;

    // Clock, reset and stimulus signals; every input starts at a known value.
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [63:0]           cfg_data = '0;

    // Flow control used by the test sequence and the result sink.
    bit quiet       = 1'b0;
    int hold_cycles = 0;
    int stall_left  = 0;

    // Bookkeeping.
    t_result event_results_q[$];
    int      n_sent      = 0;
    int      n_results   = 0;
    int      mismatches  = 0;

    // Mirror of the configuration registers.
    logic [63:0] p_rom     = '0;
    logic        p_alarm   = 1'b0;
    logic [15:0] p_rst_thr = RESET_THR_DEF;
    logic [7:0]  p_thr_std = BIT_STD_DEF;
    logic [7:0]  p_thr_od  = BIT_OD_DEF;

    // Mirror of the slave state.
    t_mode       p_mode      = MODE_IDLE;
    logic        p_od        = 1'b0;
    logic        p_selected  = 1'b0;
    logic        p_skip_rise = 1'b0;
    logic [63:0] p_txq       = '0;
    int          p_txn       = 0;
    logic [5:0]  p_sidx      = '0;
    logic [63:0] p_rxq       = '0;
    int          p_rxn       = 0;

    one_wire_slave_rom_layer_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Bus event predictor
    // ------------------------------------------------------------------

    // Append response bits; count saturates at 64, bits past it are lost.
    function automatic void enqueue_bits(logic [63:0] data, int n);
        if (n > 64) n = 64;
        if (n < 64) data &= (64'd1 << n) - 64'd1;
        if (p_txn < 64) p_txq |= data << p_txn;
        p_txn = (p_txn + n > 64) ? 64 : p_txn + n;
    endfunction

    function automatic void drop_to_idle();
        p_txq       = '0;
        p_txn       = 0;
        p_rxq       = '0;
        p_rxn       = 0;
        p_selected  = 1'b0;
        p_skip_rise = 1'b1;
        p_mode      = MODE_IDLE;
    endfunction

    // Search answers with the ROM bit and then its complement.
    function automatic void queue_search_pair();
        logic b;
        b = p_rom[p_sidx];
        enqueue_bits({62'd0, ~b, b}, 2);
    endfunction

    function automatic t_result predict_bus_event(t_cmd c, logic [15:0] us,
                                                  logic [63:0] data, logic [6:0] n);
        t_result    r;
        logic       rbit;
        logic [7:0] thr;
        logic [7:0] cbyte;
        logic       hit;
        r = '0;
        case (c)
            CMD_FALL: begin
                if (p_txn != 0) begin
                    r.drive_low = ~p_txq[0];
                    p_txq       = p_txq >> 1;
                    p_txn--;
                    p_skip_rise = 1'b1;
                    if (p_txn == 0 && (p_mode == MODE_ACTIVE || p_mode == MODE_READY))
                        r.write_done = 1'b1;
                end else begin
                    p_skip_rise = 1'b0;
                end
            end
            CMD_RISE: begin
                if (us >= p_rst_thr) begin
                    // bus reset: selection survives, everything else clears
                    p_mode      = MODE_PRESENCE;
                    p_txq       = '0;
                    p_txn       = 0;
                    p_rxq       = '0;
                    p_rxn       = 0;
                    p_skip_rise = 1'b0;
                    p_od        = 1'b0;
                    p_sidx      = '0;
                    r.presence_pulse = 1'b1;
                end else if (!p_skip_rise) begin
                    thr  = p_od ? p_thr_od : p_thr_std;
                    rbit = (us < {8'd0, thr});
                    if (p_mode == MODE_SEARCH) begin
                        if (rbit == p_rom[p_sidx]) begin
                            if (p_sidx < SEARCH_LAST) begin
                                p_sidx++;
                                queue_search_pair();
                            end else begin
                                p_mode     = MODE_ACTIVE;
                                p_selected = 1'b1;
                            end
                        end else begin
                            drop_to_idle();
                        end
                    end else if (p_mode == MODE_PRESENCE) begin
                        p_mode = MODE_AWAIT;
                    end else if (p_mode != MODE_IDLE) begin
                        if (p_rxn >= RX_BITS) begin
                            drop_to_idle();
                        end else begin
                            p_rxq[p_rxn] = rbit;
                            p_rxn++;
                            if (p_mode == MODE_AWAIT && p_rxn == 8) begin
                                cbyte = p_rxq[7:0];
                                p_rxq = '0;
                                p_rxn = 0;
                                case (cbyte)
                                    ROM_READ: begin
                                        enqueue_bits(p_rom, 64);
                                        p_mode = MODE_READROM;
                                    end
                                    ROM_OD_MATCH: begin
                                        p_od   = 1'b1;
                                        p_mode = MODE_MATCH;
                                    end
                                    ROM_MATCH: p_mode = MODE_MATCH;
                                    ROM_ALARM_SRCH, ROM_SEARCH: begin
                                        if (cbyte == ROM_ALARM_SRCH && !p_alarm) begin
                                            drop_to_idle();
                                        end else begin
                                            p_sidx = '0;
                                            p_mode = MODE_SEARCH;
                                            queue_search_pair();
                                        end
                                    end
                                    ROM_OD_SKIP: begin
                                        p_od   = 1'b1;
                                        p_mode = MODE_READY;
                                    end
                                    ROM_SKIP: p_mode = MODE_READY;
                                    ROM_RESUME: begin
                                        if (p_selected) p_mode = MODE_READY;
                                        else drop_to_idle();
                                    end
                                    default: ;
                                endcase
                            end else if (p_mode == MODE_MATCH && p_rxn == RX_BITS) begin
                                hit   = (p_rxq == p_rom);
                                p_rxq = '0;
                                p_rxn = 0;
                                if (hit) begin
                                    p_mode     = MODE_ACTIVE;
                                    p_selected = 1'b1;
                                end else begin
                                    drop_to_idle();
                                end
                            end else if ((p_mode == MODE_ACTIVE || p_mode == MODE_READY)
                                         && p_rxn == 8) begin
                                r.rx_byte       = p_rxq[7:0];
                                r.rx_byte_valid = 1'b1;
                                p_rxq = '0;
                                p_rxn = 0;
                            end
                        end
                    end
                end
            end
            CMD_QUEUE: enqueue_bits(data, int'(n));
            default: ;
        endcase
        r.bus_state = p_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver and helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Low time of a rise that is not a bus reset (if one exists).
    function automatic logic [15:0] short_us();
        if (p_rst_thr == 0) return 16'($urandom);
        return 16'($urandom_range(0, int'(p_rst_thr) - 1));
    endfunction

    // Offer one request; called and returning at a falling edge, tvalid left high.
    task automatic send_req(t_cmd c, logic [15:0] us, logic [63:0] data, logic [6:0] n);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {1'b0, n, data, us};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        event_results_q.push_back(predict_bus_event(c, us, data, n));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic noise_req();
        send_req(t_cmd'($urandom_range(0, 3)), 16'($urandom), rnd64(),
                 7'($urandom_range(0, 127)));
    endtask

    // Master write slot: a rise whose low time decodes to b at the current speed.
    task automatic send_bit(logic b);
        int          thr;
        int          lim;
        logic [15:0] us;
        thr = p_od ? int'(p_thr_od) : int'(p_thr_std);
        lim = int'(p_rst_thr);
        if (b && thr > 0 && lim > 0)
            us = 16'($urandom_range(0, ((thr < lim) ? thr : lim) - 1));
        else if (!b && thr < lim)
            us = 16'($urandom_range(thr, lim - 1));
        else
            us = 16'($urandom);
        // with nothing queued, open with a fall after our own bit, or at random
        if (p_txn == 0 && (p_skip_rise || $urandom_range(0, 3) == 0))
            send_req(CMD_FALL, 16'($urandom), rnd64(), 7'($urandom_range(0, 127)));
        send_req(CMD_RISE, us, rnd64(), 7'($urandom_range(0, 127)));
    endtask

    task automatic send_byte(logic [7:0] b);
        for (int i = 0; i < 8; i++) send_bit(b[i]);
    endtask

    // Master read slot: falling edge pops a bit, the short rise after it is ours.
    task automatic read_slot();
        send_req(CMD_FALL, 16'($urandom), rnd64(), 7'($urandom_range(0, 127)));
        send_req(CMD_RISE, short_us(), rnd64(), 7'($urandom_range(0, 127)));
    endtask

    // Reset pulse, then the rise at the end of our presence pulse.
    task automatic bus_reset();
        send_req(CMD_RISE, 16'($urandom_range(int'(p_rst_thr), 65535)), rnd64(),
                 7'($urandom_range(0, 127)));
        send_req(CMD_RISE, short_us(), rnd64(), 7'($urandom_range(0, 127)));
    endtask

    // Transport-layer traffic once selected: bytes in, responses out, some noise.
    task automatic active_traffic(int k);
        int nb;
        repeat (k) begin
            case ($urandom_range(0, 4))
                0, 1: send_byte(8'($urandom));
                2: begin
                    nb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(1, 6);
                    send_req(CMD_QUEUE, 16'($urandom), rnd64(), 7'(nb));
                    repeat ((nb > 64) ? 3 : nb) read_slot();
                end
                3: read_slot();
                default: noise_req();
            endcase
        end
    endtask

    // One transaction: reset, ROM command, then whatever the command leads to.
    task automatic rom_session();
        logic [7:0]  cmd;
        logic [63:0] addr;
        int          nbits;
        logic        b;
        if ($urandom_range(0, 7) == 0) noise_req();
        bus_reset();
        case ($urandom_range(0, 8))
            0: cmd = ROM_READ;
            1: cmd = ROM_MATCH;
            2: cmd = ROM_OD_MATCH;
            3: cmd = ROM_SKIP;
            4: cmd = ROM_OD_SKIP;
            5: cmd = ROM_SEARCH;
            6: cmd = ROM_ALARM_SRCH;
            7: cmd = ROM_RESUME;
            default: cmd = 8'($urandom);
        endcase
        send_byte(cmd);
        case (cmd)
            ROM_READ: begin
                if ($urandom_range(0, 5) == 0) begin
                    // keep writing without reading: receive overflow drops to idle
                    repeat (65) send_bit(1'($urandom_range(0, 1)));
                end else begin
                    repeat ($urandom_range(0, 64)) read_slot();
                end
            end
            ROM_MATCH, ROM_OD_MATCH: begin
                addr = p_rom;
                if ($urandom_range(0, 3) == 0) addr[$urandom_range(0, 63)] ^= 1'b1;
                for (int i = 0; i < 64; i++) send_bit(addr[i]);
                active_traffic($urandom_range(2, 10));
            end
            ROM_SEARCH, ROM_ALARM_SRCH: begin
                nbits = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 8);
                for (int i = 0; i < nbits && p_mode == MODE_SEARCH; i++) begin
                    read_slot();
                    read_slot();
                    b = p_rom[p_sidx];
                    if ($urandom_range(0, 15) == 0) b = ~b;
                    send_bit(b);
                end
                active_traffic($urandom_range(0, 6));
            end
            ROM_SKIP, ROM_OD_SKIP, ROM_RESUME: active_traffic($urandom_range(2, 10));
            default: if ($urandom_range(0, 1) == 0) send_byte(8'($urandom));
        endcase
    endtask

    // Write one register while nothing is in flight; mirror it at once.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_ROM_CODE:  p_rom     = val;
            CFG_ALARM:     p_alarm   = val[0];
            CFG_RESET_THR: p_rst_thr = val[15:0];
            CFG_BIT_STD:   p_thr_std = val[7:0];
            CFG_BIT_OD:    p_thr_od  = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(logic [63:0] rom, logic alarm, logic [15:0] rst_thr,
                              logic [7:0] std_thr, logic [7:0] od_thr);
        cfg_write(CFG_ROM_CODE, rom);
        cfg_write(CFG_ALARM, {63'd0, alarm});
        cfg_write(CFG_RESET_THR, {48'd0, rst_thr});
        cfg_write(CFG_BIT_STD, {56'd0, std_thr});
        cfg_write(CFG_BIT_OD, {56'd0, od_thr});
    endtask

    // Drop the request stream and let the pipeline empty out.
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (event_results_q.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic run_sessions(int n_items);
        int target;
        target = n_sent + n_items;
        while (n_sent < target) rom_session();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, each event kind, own-transmit rises, queue overflow.
    task automatic test_directed();
        set_config(rnd64(), 1'b0, RESET_THR_DEF, BIT_STD_DEF, BIT_OD_DEF);
        send_req(CMD_NOP, '1, '1, '1);                  // no-op: state only
        send_req(CMD_RISE, 16'd0, '0, '0);              // idle: short rise dropped
        send_req(CMD_FALL, 16'hFFFF, '1, 7'd0);         // nothing queued yet
        send_req(CMD_QUEUE, '0, '1, 7'd0);              // empty load
        send_req(CMD_QUEUE, '1, rnd64(), 7'd127);       // count above 64 clamps
        send_req(CMD_QUEUE, '0, '1, 7'd64);             // queue full: bits lost
        send_req(CMD_FALL, '0, '0, '0);                 // pops a queued bit
        send_req(CMD_RISE, 16'd1, '0, '0);              // our own bit: ignored
        send_req(CMD_RISE, 16'hFFFF, '0, '0);           // reset during transmit
        send_req(CMD_FALL, '0, '0, '0);                 // queue was flushed
        send_req(CMD_RISE, 16'd0, '0, '0);              // end of presence
        // unknown command byte 0x00 right at both thresholds; stays awaiting
        send_req(CMD_RISE, 16'd20, '0, '0);
        repeat (7) send_req(CMD_RISE, 16'd399, '1, '1);
        send_req(CMD_QUEUE, '0, 64'd1, 7'd1);
        send_req(CMD_FALL, '0, '0, '0);
        send_req(CMD_RISE, RESET_THR_DEF, '0, '0);      // reset is inclusive
        drain_wait();
    endtask

    // Random ROM transactions at nominal timing with the alarm raised.
    task automatic test_rom_sessions();
        set_config(rnd64(), 1'b1, RESET_THR_DEF, BIT_STD_DEF, BIT_OD_DEF);
        run_sessions(40);
        drain_wait();
    endtask

    // Walk a full search to selection, then resume the selected device.
    task automatic test_search_select();
        cfg_write(CFG_ROM_CODE, rnd64());
        bus_reset();
        send_byte(ROM_SEARCH);
        for (int i = 0; i < 64 && p_mode == MODE_SEARCH; i++) begin
            read_slot();
            read_slot();
            send_bit(p_rom[p_sidx]);
        end
        active_traffic(3);
        bus_reset();
        send_byte(ROM_RESUME);
        active_traffic(3);
        drain_wait();
    endtask

    // Hold the result side off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        @(posedge clk);
        hold_cycles = 80;
        @(negedge clk);
        bus_reset();
        send_byte(ROM_SKIP);
        active_traffic(6);
        drain_wait();
    endtask

    // Threshold extremes: widest windows, then every rise a reset.
    task automatic test_extreme_thresholds();
        set_config('1, 1'b0, 16'hFFFF, 8'hFF, 8'h00);
        run_sessions(30);
        drain_wait();
        set_config('0, 1'b1, 16'd0, 8'h00, 8'hFF);
        repeat (10) noise_req();
        run_sessions(10);
        drain_wait();
    endtask

    // Closing stretch at full rate on both sides with random timing.
    task automatic test_quiet_tail();
        logic [15:0] rst_thr;
        logic [7:0]  std_thr;
        rst_thr = 16'($urandom_range(50, 2000));
        std_thr = 8'($urandom_range(1, 49));
        @(posedge clk);
        quiet = 1'b1;
        @(negedge clk);
        set_config(rnd64(), 1'($urandom_range(0, 1)), rst_thr, std_thr,
                   8'($urandom_range(0, int'(std_thr))));
        run_sessions(40);
        drain_wait();
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus the long hold-off when requested
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void note_mismatch(string fld, logic [15:0] want, logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d: %s expected %0h, got %0h", n_results, fld, want, got);
    endfunction

    // Compare each accepted result against the oldest prediction.
    always @(posedge clk) begin : result_check
        t_result     want;
        logic [15:0] got;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (event_results_q.size() == 0) begin
                note_mismatch("unrequested result", 16'h0, got);
            end else begin
                want = event_results_q.pop_front();
                if (got[0] !== want.drive_low)
                    note_mismatch("drive_low", 16'(want.drive_low), 16'(got[0]));
                if (got[1] !== want.presence_pulse)
                    note_mismatch("presence_pulse", 16'(want.presence_pulse), 16'(got[1]));
                if (got[9:2] !== want.rx_byte)
                    note_mismatch("rx_byte", 16'(want.rx_byte), 16'(got[9:2]));
                if (got[10] !== want.rx_byte_valid)
                    note_mismatch("rx_byte_valid", 16'(want.rx_byte_valid), 16'(got[10]));
                if (got[11] !== want.write_done)
                    note_mismatch("write_done", 16'(want.write_done), 16'(got[11]));
                if (got[14:12] !== want.bus_state)
                    note_mismatch("bus_state", 16'(want.bus_state), 16'(got[14:12]));
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests in turn, wait out the pipeline
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_rom_sessions();
        test_search_select();
        test_backpressure();
        test_extreme_thresholds();
        test_quiet_tail();
        drain_wait();
        repeat (10) @(negedge clk);
        // any request still without its result counts against the run
        mismatches += event_results_q.size();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
